FILE: rtl/julia_escape_time_pixel_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julia escape-time pixel core
// Clocked on clk_i; the reset-qualified form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define JET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jet assertion failed");
// Checked on every edge, reset included.
`define JET_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("jet assertion failed");
`else
`define JET_ASSERT(lbl, prop)
`define JET_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/jet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg
// Shared constants, types, microcode ROM and helpers of the Julia pixel core.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int unsigned MAX_ITER    = 255;
  localparam int unsigned CNT_W       = $clog2(MAX_ITER + 1);
  localparam int unsigned ITER_W      = 8;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PROD_W      = 2 * DATA_W;
  localparam int unsigned FRAC_BITS   = 28;
  // |z|^2 in Q8.56 escapes at 4 = 2^(2*FRAC_BITS+2)
  localparam int unsigned ESC_BIT     = 2 * FRAC_BITS + 2;
  localparam int unsigned PAL_FACTOR  = 70;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_START   = 3'd0,
    REG_REAL_STEP    = 3'd1,
    REG_IMAG_START   = 3'd2,
    REG_IMAG_STEP    = 3'd3,
    REG_CONST_REAL   = 3'd4,
    REG_CONST_IMAG   = 3'd5,
    REG_PALETTE_MODE = 3'd6,
    REG_BASE_COLOR   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PAL_NONE   = 2'd0,
    PAL_LINEAR = 2'd1,
    PAL_SCALED = 2'd2
  } pal_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] real_start;
    logic [DATA_W-1:0] real_step;
    logic [DATA_W-1:0] imag_start;
    logic [DATA_W-1:0] imag_step;
    logic [DATA_W-1:0] const_real;
    logic [DATA_W-1:0] const_imag;
    logic [1:0]        palette_mode;
    logic [DATA_W-1:0] base_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    real_start:   32'hE000_0000,
    real_step:    32'h0010_0000,
    imag_start:   32'hE000_0000,
    imag_step:    32'h0010_0000,
    const_real:   32'hF333_3333,
    const_imag:   32'h027E_F9DB,
    palette_mode: PAL_LINEAR,
    base_color:   32'h0001_0101
  };

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_COL_RSTEP,
    MUL_ROW_ISTEP,
    MUL_ZR_ZR,
    MUL_ZI_ZI,
    MUL_ZR_ZI,
    MUL_CNT_K,
    MUL_BASE_FAC
  } mul_op_e;

  typedef enum logic [1:0] {
    Z_HOLD,
    Z_LOAD_RE,
    Z_LOAD_IM,
    Z_ITER
  } z_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ONE,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [1:0] {
    RR_HOLD,
    RR_LOAD,
    RR_SUB
  } rr_op_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT,
    J_DONE,
    J_ALWAYS
  } jump_e;

  localparam int unsigned UCODE_LEN = 12;
  localparam int unsigned STEP_W    = $clog2(UCODE_LEN);

  localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_MAP_RE = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MAP_IM = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_SEED   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_LOOP   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_SQ_IM  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_TEST   = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_UPDATE = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_PAL    = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_FAC    = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_COLOR  = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_EMIT   = STEP_W'(11);

  typedef struct packed {
    mul_op_e           mul_op;
    z_op_e             z_op;
    cnt_op_e           cnt_op;
    rr_op_e            rr_op;
    logic              fac_we;
    logic              out_we;
    jump_e             jump;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic done;
  } stat_t;

  // Microprogram: one control word per step
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{mul_op: MUL_NONE, z_op: Z_HOLD, cnt_op: CNT_HOLD, rr_op: RR_HOLD,
          fac_we: 1'b0, out_we: 1'b0, jump: J_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        c.jump   = J_WAIT;
        c.target = STEP_IDLE;
      end
      STEP_MAP_RE: c.mul_op = MUL_COL_RSTEP;
      STEP_MAP_IM: begin
        c.z_op   = Z_LOAD_RE;
        c.mul_op = MUL_ROW_ISTEP;
      end
      STEP_SEED: begin
        c.z_op   = Z_LOAD_IM;
        c.cnt_op = CNT_ONE;
      end
      STEP_LOOP: c.mul_op = MUL_ZR_ZR;
      STEP_SQ_IM: begin
        c.rr_op  = RR_LOAD;
        c.mul_op = MUL_ZI_ZI;
      end
      STEP_TEST: begin
        c.rr_op  = RR_SUB;
        c.mul_op = MUL_ZR_ZI;
        c.jump   = J_DONE;
        c.target = STEP_PAL;
      end
      STEP_UPDATE: begin
        c.z_op   = Z_ITER;
        c.cnt_op = CNT_INC;
        c.jump   = J_ALWAYS;
        c.target = STEP_LOOP;
      end
      STEP_PAL:   c.mul_op = MUL_CNT_K;
      STEP_FAC:   c.fac_we = 1'b1;
      STEP_COLOR: c.mul_op = MUL_BASE_FAC;
      STEP_EMIT: begin
        c.out_we = 1'b1;
        c.jump   = J_ALWAYS;
        c.target = STEP_IDLE;
      end
      default: begin
        c.jump   = J_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [PROD_W-1:0] sext64(input logic [DATA_W-1:0] v);
    return $signed({{(PROD_W-DATA_W){v[DATA_W-1]}}, v});
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [DATA_W-1:0] r;
    if ((v[PROD_W-1:DATA_W-1] == '0) || (v[PROD_W-1:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/jet_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module jet_cfg_regs import jet_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_REAL_START:   cfg_d.real_start   = cfg_wdata_i;
        REG_REAL_STEP:    cfg_d.real_step    = cfg_wdata_i;
        REG_IMAG_START:   cfg_d.imag_start   = cfg_wdata_i;
        REG_IMAG_STEP:    cfg_d.imag_step    = cfg_wdata_i;
        REG_CONST_REAL:   cfg_d.const_real   = cfg_wdata_i;
        REG_CONST_IMAG:   cfg_d.const_imag   = cfg_wdata_i;
        REG_PALETTE_MODE: cfg_d.palette_mode = cfg_wdata_i[1:0];
        REG_BASE_COLOR:   cfg_d.base_color   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/jet_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_core_assert.svh"

module jet_useq import jet_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy
);

  logic [STEP_W-1:0] step_q, step_d;

  assign ctrl_o = ucode_rom(step_q);
  assign busy   = (step_q != STEP_IDLE);

  always_comb begin
    case (ctrl_o.jump)
      J_NEXT:   step_d = step_q + STEP_W'(1);
      J_WAIT:   step_d = start ? step_q + STEP_W'(1) : ctrl_o.target;
      J_DONE:   step_d = stat_i.done ? ctrl_o.target : step_q + STEP_W'(1);
      J_ALWAYS: step_d = ctrl_o.target;
      default:  step_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  `JET_ASSERT(a_step_in_rom, step_q < STEP_W'(UCODE_LEN))

endmodule

FILE: rtl/jet_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_datapath
// One 32x32 multiplier, z / count / partial-sum registers and result regs.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_core_assert.svh"

module jet_datapath import jet_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [COORD_W-1:0] pixel_col_i,
  input  logic [COORD_W-1:0] pixel_row_i,
  input  cfg_t               cfg_i,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  output logic [ITER_W-1:0]  iter_count_o,
  output logic [DATA_W-1:0]  pixel_color_o,
  output logic               result_strobe_o
);

  logic [COORD_W-1:0]       col_q, row_q;
  logic [DATA_W-1:0]        zr_q, zr_d, zi_q, zi_d;
  logic signed [PROD_W-1:0] p_q, rr_q, rr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DATA_W-1:0]        fac_q;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic                     at_max;
  logic                     pal_on;
  logic [ITER_W-1:0]        iter_q;
  logic [DATA_W-1:0]        color_q, color_d;
  logic                     strobe_q;

  always_comb begin
    case (ctrl_i.mul_op)
      MUL_COL_RSTEP: begin
        mul_a = $signed(DATA_W'(col_q));
        mul_b = $signed(cfg_i.real_step);
      end
      MUL_ROW_ISTEP: begin
        mul_a = $signed(DATA_W'(row_q));
        mul_b = $signed(cfg_i.imag_step);
      end
      MUL_ZR_ZR: begin
        mul_a = $signed(zr_q);
        mul_b = $signed(zr_q);
      end
      MUL_ZI_ZI: begin
        mul_a = $signed(zi_q);
        mul_b = $signed(zi_q);
      end
      MUL_ZR_ZI: begin
        mul_a = $signed(zr_q);
        mul_b = $signed(zi_q);
      end
      MUL_CNT_K: begin
        mul_a = $signed(DATA_W'(cnt_q));
        mul_b = $signed(DATA_W'(PAL_FACTOR));
      end
      MUL_BASE_FAC: begin
        // only the low word is kept, so signedness does not matter
        mul_a = $signed(cfg_i.base_color);
        mul_b = $signed(fac_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // rr_q holds zr^2 and p_q holds zi^2 during the test step; both non-negative
  assign mag    = rr_q + p_q;
  assign at_max = (cnt_q >= CNT_W'(MAX_ITER));
  assign stat_o.done = (|mag[PROD_W-1:ESC_BIT]) || at_max;

  always_comb begin
    zr_d = zr_q;
    zi_d = zi_q;
    case (ctrl_i.z_op)
      Z_LOAD_RE: zr_d = sat32(sext64(cfg_i.real_start) + p_q);
      Z_LOAD_IM: zi_d = sat32(sext64(cfg_i.imag_start) + p_q);
      Z_ITER: begin
        zr_d = sat32((rr_q >>> FRAC_BITS) + sext64(cfg_i.const_real));
        zi_d = sat32((p_q >>> (FRAC_BITS - 1)) + sext64(cfg_i.const_imag));
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl_i.rr_op)
      RR_LOAD: rr_d = p_q;
      RR_SUB:  rr_d = rr_q - p_q;
      default: rr_d = rr_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_ONE: cnt_d = CNT_W'(1);
      CNT_INC: cnt_d = cnt_q + CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  assign pal_on = (cfg_i.palette_mode == PAL_LINEAR) || (cfg_i.palette_mode == PAL_SCALED);

  always_comb begin
    if (!pal_on) begin
      color_d = '0;
    end else if (at_max) begin
      color_d = cfg_i.base_color;
    end else begin
      color_d = p_q[DATA_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    if (ctrl_i.mul_op != MUL_NONE) begin
      p_q <= prod;
    end
    zr_q <= zr_d;
    zi_q <= zi_d;
    rr_q <= rr_d;
    if (ctrl_i.fac_we) begin
      fac_q <= (cfg_i.palette_mode == PAL_SCALED) ? p_q[DATA_W-1:0] + DATA_W'(1)
                                                  : DATA_W'(cnt_q);
    end
    if (ctrl_i.out_we) begin
      iter_q  <= ITER_W'(cnt_q);
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      strobe_q <= ctrl_i.out_we;
    end
  end

  assign iter_count_o    = iter_q;
  assign pixel_color_o   = color_q;
  assign result_strobe_o = strobe_q;

  `JET_ASSERT(a_cnt_bounded, cnt_q <= CNT_W'(MAX_ITER))

endmodule

FILE: rtl/julia_escape_time_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core
// Julia-set escape-time engine in Q4.28: maps a pixel to z0, iterates
// z = z^2 + c until |z|^2 >= 4 or MAX_ITER, returns count and colour.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  -------------------------
//  command   in         start high, busy low           pixel_col_i, pixel_row_i
//  result    out        result_strobe_o (one cycle)    iter_count_o, pixel_color_o
//  config    in         cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
//  Each iteration is four microcode steps on the single shared 32x32
//  multiplier: zr^2, zi^2, zr*zi with the escape test, then the z update.
//  busy drops in the strobe cycle, so the next start transfer can coincide
//  with the result transfer.
//  Reset: asynchronous, active low; config returns to its defaults, the
//  sequencer to idle. The receiver cannot stall the result transfer.
//
`include "julia_escape_time_pixel_core_assert.svh"

module julia_escape_time_pixel_core import jet_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   pixel_col_i,
  input  logic [COORD_W-1:0]   pixel_row_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  // result
  output logic                 result_strobe_o,
  output logic [ITER_W-1:0]    iter_count_o,
  output logic [DATA_W-1:0]    pixel_color_o
);

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  // start transfer: only the idle step takes a new pixel
  assign accept = start && !busy;

  jet_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // control program: map, seed, iterate (4 steps each), palette, emit
  jet_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  jet_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .pixel_col_i     (pixel_col_i),
    .pixel_row_i     (pixel_row_i),
    .cfg_i           (cfg),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .iter_count_o    (iter_count_o),
    .pixel_color_o   (pixel_color_o),
    .result_strobe_o (result_strobe_o)
  );

  // A start transfer puts the sequencer to work on the next cycle.
  `JET_ASSERT(a_accept_busy, accept |=> busy)
  // The result appears only once the program has returned to idle.
  `JET_ASSERT(a_strobe_idle, result_strobe_o |-> !busy)
  // The result of one pixel is strobed once.
  `JET_ASSERT(a_strobe_single, result_strobe_o |=> !result_strobe_o)

endmodule

FILE: test/julia_escape_time_pixel_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core_test
// Self-checking bench for the Julia escape-time pixel core: pixel commands go
// in through start/busy, and every result strobe is compared with a Q4.28
// escape-time prediction made when its command transfer happened.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core_test;
  import jet_pkg::*;

  localparam int unsigned    CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0]     PAL_UNUSED  = 2'd3;     // undefined mode code, colors 0
  localparam longint         Q_MAX       = 64'sd2147483647;
  localparam longint         Q_MIN       = -64'sd2147483648;
  localparam longint unsigned ESC_LIMIT  = 64'd1 << ESC_BIT;  // 4.0 in Q8.56

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_cmd_t;

  typedef struct packed {
    logic [ITER_W-1:0] iters;
    logic [DATA_W-1:0] color;
  } pixel_result_t;

  // Shadow of the block's register file
  typedef struct {
    logic signed [DATA_W-1:0] re_origin;
    logic signed [DATA_W-1:0] re_pitch;
    logic signed [DATA_W-1:0] im_origin;
    logic signed [DATA_W-1:0] im_pitch;
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic [1:0]               shade;
    logic [DATA_W-1:0]        tint;
  } view_regs_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   pixel_col = '0;
  logic [COORD_W-1:0]   pixel_row = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_REAL_START;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 result_strobe;
  logic [ITER_W-1:0]    iter_count;
  logic [DATA_W-1:0]    pixel_color;

  view_regs_t    view;
  pixel_cmd_t    pixel_pending[$];   // commands not yet offered to the core
  pixel_result_t pixel_expected[$];  // predictions waiting for their strobe
  int unsigned   sender_idle_pct = 0;
  bit            drain_hold = 1'b0;  // offer the next pixel only when drained
  bit            cmd_taken = 1'b0;   // start transfer at the last rising edge
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  julia_escape_time_pixel_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .pixel_col_i     (pixel_col),
    .pixel_row_i     (pixel_row),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .result_strobe_o (result_strobe),
    .iter_count_o    (iter_count),
    .pixel_color_o   (pixel_color)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] row);
    longint          zr, zi, rr, ii, nr, ni;
    longint unsigned mag;
    int unsigned     count;
    logic [DATA_W-1:0] fac;
    pixel_result_t   r;
    // Start point is exact, then clamped to Q4.28; columns past the image
    // width map through the same line.
    zr = clamp_q428(longint'(view.re_origin) + longint'(col) * longint'(view.re_pitch));
    zi = clamp_q428(longint'(view.im_origin) + longint'(row) * longint'(view.im_pitch));
    count = 1;
    forever begin
      rr  = zr * zr;
      ii  = zi * zi;
      mag = longint'(rr) + longint'(ii);  // Q8.56, at most 2^63, no wrap unsigned
      if (!(mag < ESC_LIMIT && count < MAX_ITER)) break;
      // >>> on a signed longint is a floor division by the power of two
      nr = clamp_q428(((rr - ii) >>> FRAC_BITS) + longint'(view.c_re));
      ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + longint'(view.c_im));
      zr = nr;
      zi = ni;
      count++;
    end
    r.iters = ITER_W'(count);
    if (view.shade == PAL_LINEAR || view.shade == PAL_SCALED) begin
      if (count == MAX_ITER) begin
        r.color = view.tint;               // never escaped: flat base color
      end else if (view.shade == PAL_LINEAR) begin
        r.color = view.tint * DATA_W'(count);
      end else begin
        fac     = DATA_W'(count) * DATA_W'(PAL_FACTOR) + 1;
        r.color = view.tint * fac;
      end
    end else begin
      r.color = '0;                        // mode none and the unused code
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: rising edge. Checks the strobe first, then records a new command
  // transfer; both can land on the same edge since busy drops with the strobe.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    pixel_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
    if (rst_ni) begin
      if (result_strobe === 1'b1) begin
        if (pixel_expected.size() == 0) begin
          flag_mismatch("result with nothing pending", 64'd0,
                        64'({iter_count, pixel_color}));
        end else begin
          want = pixel_expected.pop_front();
          if (iter_count !== want.iters)
            flag_mismatch("iter_count", 64'(want.iters), 64'(iter_count));
          if (pixel_color !== want.color)
            flag_mismatch("pixel_color", 64'(want.color), 64'(pixel_color));
        end
      end
      cmd_taken = (start === 1'b1) && (busy === 1'b0);
      if (cmd_taken) pixel_expected.push_back(escape_pixel(pixel_col, pixel_row));
    end
  end

  // --------------------------------------------------------------------------
  // Driver: falling edge. A new pixel is offered once the previous one has
  // transferred; idle cycles are drawn per cycle at sender_idle_pct.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : cmd_driver
    pixel_cmd_t nxt;
    if (rst_ni && (!start || cmd_taken)) begin
      if (pixel_pending.size() != 0 && !(drain_hold && pixel_expected.size() != 0) &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt = pixel_pending.pop_front();
        pixel_col <= nxt.col;
        pixel_row <= nxt.row;
        start     <= 1'b1;
      end else begin
        // noise on the coordinates while no command is offered
        pixel_col <= COORD_W'($urandom);
        pixel_row <= COORD_W'($urandom);
        start     <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input int unsigned col, input int unsigned row);
    pixel_cmd_t c;
    c.col = COORD_W'(col);
    c.row = COORD_W'(row);
    pixel_pending.push_back(c);
  endtask

  // Block until every queued pixel has transferred and its result arrived.
  // Returns at a falling edge, ready for register writes.
  task automatic settle();
    @(posedge clk_i);
    while (pixel_pending.size() != 0 || start || busy || pixel_expected.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Called at a falling edge with the core idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    case (idx)
      REG_REAL_START:   view.re_origin = val;
      REG_REAL_STEP:    view.re_pitch  = val;
      REG_IMAG_START:   view.im_origin = val;
      REG_IMAG_STEP:    view.im_pitch  = val;
      REG_CONST_REAL:   view.c_re      = val;
      REG_CONST_IMAG:   view.c_im      = val;
      REG_PALETTE_MODE: view.shade     = val[1:0];
      REG_BASE_COLOR:   view.tint      = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic write_view(input logic [DATA_W-1:0] re0, input logic [DATA_W-1:0] dre,
                            input logic [DATA_W-1:0] im0, input logic [DATA_W-1:0] dim,
                            input logic [DATA_W-1:0] cre, input logic [DATA_W-1:0] cim);
    write_reg(REG_REAL_START, re0);
    write_reg(REG_REAL_STEP, dre);
    write_reg(REG_IMAG_START, im0);
    write_reg(REG_IMAG_STEP, dim);
    write_reg(REG_CONST_REAL, cre);
    write_reg(REG_CONST_IMAG, cim);
  endtask

  function automatic logic [DATA_W-1:0] pick_step();
    logic [DATA_W-1:0] s;
    s = $urandom_range(32'h0020_0000, 32'h0001_0000);
    return ($urandom_range(3) == 0) ? -s : s;
  endfunction

  // Mostly a plausible window around the set with c inside +/-1, so pixels
  // iterate deep; now and then every register is fully random.
  task automatic random_view();
    if ($urandom_range(3) == 0) begin
      write_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      write_view(32'hE000_0000 + $urandom_range(32'h0800_0000) - 32'h0400_0000,
                 pick_step(),
                 32'hE000_0000 + $urandom_range(32'h0800_0000) - 32'h0400_0000,
                 pick_step(),
                 $urandom_range(32'h2000_0000) - 32'h1000_0000,
                 $urandom_range(32'h2000_0000) - 32'h1000_0000);
    end
    write_reg(REG_PALETTE_MODE, $urandom_range(3));
    write_reg(REG_BASE_COLOR, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    // register defaults after reset
    view.re_origin = 32'hE000_0000;   // -2.0
    view.re_pitch  = 32'h0010_0000;   // 1/256
    view.im_origin = 32'hE000_0000;
    view.im_pitch  = 32'h0010_0000;
    view.c_re      = -32'sd214748365; // about -0.8
    view.c_im      = 32'sd41875931;   // about 0.156
    view.shade     = PAL_LINEAR;
    view.tint      = 32'h0001_0101;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default view: image corners escape at once, the middle stays bounded.
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(512, 512);
    queue_pixel(600, 520);
    settle();

    // z and c pinned to zero: never escapes, color is the base in both
    // palette modes, zero for mode none and the unused code.
    write_view('0, '0, '0, '0, '0, '0);
    write_reg(REG_BASE_COLOR, 32'hFFFF_FFFF);
    queue_pixel(3, 4);
    settle();
    write_reg(REG_PALETTE_MODE, DATA_W'(PAL_SCALED));
    queue_pixel(5, 5);
    settle();
    write_reg(REG_PALETTE_MODE, DATA_W'(PAL_UNUSED));
    queue_pixel(7, 9);
    settle();
    write_reg(REG_PALETTE_MODE, DATA_W'(PAL_NONE));
    queue_pixel(1, 1);
    settle();

    // Extreme registers: start points clamp at the Q4.28 rails.
    write_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(REG_PALETTE_MODE, DATA_W'(PAL_SCALED));
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    settle();

    // z just under 2 with extreme c: the update clamps, escape at count 2,
    // and the color products wrap.
    write_view(32'h1FFF_FFFF, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_pixel(11, 22);
    settle();
    write_reg(REG_PALETTE_MODE, DATA_W'(PAL_LINEAR));
    queue_pixel(33, 44);
    settle();

    // Random part: eight views, cycling through the idle profiles.
    for (phase = 0; phase < 8; phase++) begin
      random_view();
      case (phase % 4)
        1:       sender_idle_pct = 77;
        3:       sender_idle_pct = 8;
        default: sender_idle_pct = 0;  // incl. receiver profile: it cannot stall
      endcase
      drain_hold = (phase == 5);
      repeat (50) queue_pixel($urandom_range(1023), $urandom_range(1023));
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_cfg_regs.sv
rtl/jet_useq.sv
rtl/jet_datapath.sv
rtl/julia_escape_time_pixel_core.sv
test/julia_escape_time_pixel_core_test.sv
